// ===== rtl/vnos_pkg.sv =====
package vnos_pkg;

    // Default sizes; the top level hands them down as parameters.
    localparam int MAX_OCTAVES_DEF       = 16;
    localparam int COS_TABLE_ENTRIES_DEF = 256;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 4'd1;

    localparam logic [4:0]  OCTAVE_COUNT_RST = 5'd8;
    localparam logic [16:0] PERSIST_RST      = 17'd32768;
    localparam logic [16:0] PERSIST_ONE      = 17'd65536;

    // Pi in unsigned Q2.30.
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Divisors (2n)(2n+1) of the sine series terms.
    localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_INIT,
        OP_CLEAR,
        OP_HASH_N,
        OP_HASH_SQ,
        OP_HASH_K,
        OP_HASH_MUL,
        OP_HASH_ACC,
        OP_MUL_BA,
        OP_ADD_BA,
        OP_MUL_BB,
        OP_ADD_BB,
        OP_MUL_BC,
        OP_ADD_BC,
        OP_MUL_SC,
        OP_ADD_SC,
        OP_MUL_AMP,
        OP_NEXT_OCT,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] gi;
        logic [1:0] gj;
    } dp_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OCT,
        ST_HN,
        ST_HSQ,
        ST_HK,
        ST_HM,
        ST_HACC,
        ST_BMA,
        ST_BAA,
        ST_BMB,
        ST_BAB,
        ST_BMC,
        ST_BAC,
        ST_SCM,
        ST_SCA,
        ST_AMM,
        ST_AMN,
        ST_DONE
    } ctrl_state_t;

    // Blend weight sin^2 of a half angle given in Q2.30, as Q0.16 capped at one.
    // Used only to build the constant blend table at elaboration.
    function automatic logic [16:0] cos_weight(input logic [63:0] b);
        logic [63:0] b2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] f;
        logic [63:0] w;
        b2   = (b * b) >> 30;
        term = b;
        s    = b;
        for (int n = 1; n <= 8; n++)
        begin
            term = (term * b2) >> 30;
            term = term / SERIES_DIV[n-1];
            if (n[0])
                s = (s >= term) ? s - term : 64'd0;
            else
                s = s + term;
        end
        f = (s * s) >> 30;
        w = (f + 64'd8192) >> 14;
        if (w > 64'd65536)
            w = 64'd65536;
        return w[16:0];
    endfunction

endpackage

// ===== rtl/vnos_ctrl.sv =====
module vnos_ctrl
    import vnos_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
    localparam int LOOP_W = $clog2(MAX_OCTAVES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LOOP_W-1:0] loops,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output dp_cmd_t           cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [LOOP_W-1:0] oct_reg, oct_next;
    logic [3:0]        grid_reg, grid_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oct_reg       <= '0;
            grid_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oct_reg       <= oct_next;
            grid_reg      <= grid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        oct_next       = oct_reg;
        grid_next      = grid_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd.op         = OP_IDLE;
        cmd.gi         = grid_reg[1:0];
        cmd.gj         = grid_reg[3:2];
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_INIT;
                    oct_next   = '0;
                    state_next = ST_OCT;
                end
            end
            ST_OCT:
            begin
                if (oct_reg == loops)
                    state_next = ST_DONE;
                else
                begin
                    cmd.op     = OP_CLEAR;
                    grid_next  = '0;
                    state_next = ST_HN;
                end
            end
            ST_HN:
            begin
                cmd.op     = OP_HASH_N;
                state_next = ST_HSQ;
            end
            ST_HSQ:
            begin
                cmd.op     = OP_HASH_SQ;
                state_next = ST_HK;
            end
            ST_HK:
            begin
                cmd.op     = OP_HASH_K;
                state_next = ST_HM;
            end
            ST_HM:
            begin
                cmd.op     = OP_HASH_MUL;
                state_next = ST_HACC;
            end
            ST_HACC:
            begin
                cmd.op    = OP_HASH_ACC;
                grid_next = grid_reg + 4'd1;
                if (grid_reg == 4'd15)
                    state_next = ST_BMA;
                else
                    state_next = ST_HN;
            end
            ST_BMA:
            begin
                cmd.op     = OP_MUL_BA;
                state_next = ST_BAA;
            end
            ST_BAA:
            begin
                cmd.op     = OP_ADD_BA;
                state_next = ST_BMB;
            end
            ST_BMB:
            begin
                cmd.op     = OP_MUL_BB;
                state_next = ST_BAB;
            end
            ST_BAB:
            begin
                cmd.op     = OP_ADD_BB;
                state_next = ST_BMC;
            end
            ST_BMC:
            begin
                cmd.op     = OP_MUL_BC;
                state_next = ST_BAC;
            end
            ST_BAC:
            begin
                cmd.op     = OP_ADD_BC;
                state_next = ST_SCM;
            end
            ST_SCM:
            begin
                cmd.op     = OP_MUL_SC;
                state_next = ST_SCA;
            end
            ST_SCA:
            begin
                cmd.op     = OP_ADD_SC;
                state_next = ST_AMM;
            end
            ST_AMM:
            begin
                cmd.op     = OP_MUL_AMP;
                state_next = ST_AMN;
            end
            ST_AMN:
            begin
                cmd.op     = OP_NEXT_OCT;
                oct_next   = oct_reg + LOOP_W'(1);
                state_next = ST_OCT;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/vnos_dp.sv =====
module vnos_dp
    import vnos_pkg::*;
#(
    parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES)
)
(
    input  logic               clk,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic        [16:0] persistence,
    output logic signed [39:0] noise_sum
);

    // Constant blend table.
    logic [16:0] cos_tbl [COS_TABLE_ENTRIES];

    for (genvar k = 0; k < COS_TABLE_ENTRIES; k++)
    begin : g_tbl
        localparam logic [63:0] ANGLE = (PI_Q30 * 64'(k)) / (64'(2 * COS_TABLE_ENTRIES));
        localparam logic [16:0] WT    = cos_weight(ANGLE);
        assign cos_tbl[k] = WT;
    end

    logic               sx_reg, sx_next, sy_reg, sy_next;
    logic        [47:0] magx_reg, magx_next, magy_reg, magy_next;
    logic        [31:0] n_reg, n_next, hm_reg, hm_next;
    logic signed [35:0] acc_reg [4];
    logic signed [35:0] acc_next [4];
    logic signed [51:0] prod_reg, prod_next;
    logic signed [33:0] i1_reg, i1_next, i2_reg, i2_next, nv_reg, nv_next;
    logic        [16:0] amp_reg, amp_next;
    logic signed [39:0] total_reg, total_next, out_reg, out_next;

    logic        [31:0] wx, wy, xl, yl, n0, t_val;
    logic        [31:0] scx, scy;
    logic        [16:0] wgt_x, wgt_y;
    logic signed [35:0] lat_val;
    logic signed [33:0] sm [4];
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [40:0] sum41;
    logic        [2:0]  dx, dy;

    // Lattice base point and blend weights of this octave.
    assign wx  = sx_reg ? 32'd0 - magx_reg[47:16] : magx_reg[47:16];
    assign wy  = sy_reg ? 32'd0 - magy_reg[47:16] : magy_reg[47:16];
    assign scx = {16'd0, magx_reg[15:0]} * 32'(COS_TABLE_ENTRIES);
    assign scy = {16'd0, magy_reg[15:0]} * 32'(COS_TABLE_ENTRIES);
    assign wgt_x = cos_tbl[scx[16 +: IDX_W]];
    assign wgt_y = cos_tbl[scy[16 +: IDX_W]];

    assign xl = wx + {30'd0, cmd.gi} - 32'd1;
    assign yl = wy + {30'd0, cmd.gj} - 32'd1;
    assign n0 = xl + (yl << 6) - (yl << 3) + yl;

    assign t_val   = (hm_reg + 32'd1376312589) & 32'h7fffffff;
    assign lat_val = 36'sd1073741824 - $signed({4'd0, t_val});

    always_comb
    begin
        for (int a = 0; a < 4; a++)
            sm[a] = 34'(acc_reg[a] >>> 4);
    end

    always_comb
    begin
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        magx_next  = magx_reg;
        magy_next  = magy_reg;
        n_next     = n_reg;
        hm_next    = hm_reg;
        prod_next  = prod_reg;
        i1_next    = i1_reg;
        i2_next    = i2_reg;
        nv_next    = nv_reg;
        amp_next   = amp_reg;
        total_next = total_reg;
        out_next   = out_reg;
        mul_a      = '0;
        mul_b      = '0;
        sum41      = '0;
        dx         = '0;
        dy         = '0;
        for (int a = 0; a < 4; a++)
            acc_next[a] = acc_reg[a];
        case (cmd.op)
            OP_INIT:
            begin
                sx_next    = x_coord[31];
                sy_next    = y_coord[31];
                magx_next  = {16'd0, x_coord[31] ? 32'd0 - x_coord : x_coord};
                magy_next  = {16'd0, y_coord[31] ? 32'd0 - y_coord : y_coord};
                amp_next   = PERSIST_ONE;
                total_next = '0;
            end
            OP_CLEAR:
            begin
                for (int a = 0; a < 4; a++)
                    acc_next[a] = '0;
            end
            OP_HASH_N:   n_next  = (n0 << 13) ^ n0;
            OP_HASH_SQ:  hm_next = n_reg * n_reg;
            OP_HASH_K:   hm_next = hm_reg * 32'd15731;
            OP_HASH_MUL: hm_next = n_reg * (hm_reg + 32'd789221);
            OP_HASH_ACC:
            begin
                // Each lattice value feeds the 3x3 windows of the four smoothed
                // values around the point: center 4, side 2, corner 1.
                for (int a = 0; a < 4; a++)
                begin
                    dx = {1'b0, cmd.gi} - {2'd0, a[0]};
                    dy = {1'b0, cmd.gj} - {2'd0, a[1]};
                    if (dx <= 3'd2 && dy <= 3'd2)
                    begin
                        if (dx == 3'd1 && dy == 3'd1)
                            acc_next[a] = acc_reg[a] + (lat_val <<< 2);
                        else if (dx == 3'd1 || dy == 3'd1)
                            acc_next[a] = acc_reg[a] + (lat_val <<< 1);
                        else
                            acc_next[a] = acc_reg[a] + lat_val;
                    end
                end
            end
            OP_MUL_BA:
            begin
                mul_a     = sm[1] - sm[0];
                mul_b     = $signed({1'b0, wgt_x});
                prod_next = mul_a * mul_b;
            end
            OP_ADD_BA: i1_next = sm[0] + 34'(prod_reg >>> 16);
            OP_MUL_BB:
            begin
                mul_a     = sm[3] - sm[2];
                mul_b     = $signed({1'b0, wgt_x});
                prod_next = mul_a * mul_b;
            end
            OP_ADD_BB: i2_next = sm[2] + 34'(prod_reg >>> 16);
            OP_MUL_BC:
            begin
                mul_a     = i2_reg - i1_reg;
                mul_b     = $signed({1'b0, wgt_y});
                prod_next = mul_a * mul_b;
            end
            OP_ADD_BC: nv_next = i1_reg + 34'(prod_reg >>> 16);
            OP_MUL_SC:
            begin
                mul_a     = nv_reg;
                mul_b     = $signed({1'b0, amp_reg});
                prod_next = mul_a * mul_b;
            end
            OP_ADD_SC:
            begin
                sum41 = {total_reg[39], total_reg} + 41'(prod_reg >>> 16);
                if (sum41[40] != sum41[39])
                    total_next = sum41[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
                else
                    total_next = sum41[39:0];
            end
            OP_MUL_AMP:
            begin
                mul_a     = $signed({17'd0, amp_reg});
                mul_b     = $signed({1'b0, persistence});
                prod_next = mul_a * mul_b;
            end
            OP_NEXT_OCT:
            begin
                amp_next  = prod_reg[32:16];
                magx_next = magx_reg << 1;
                magy_next = magy_reg << 1;
            end
            OP_LOAD_OUT: out_next = total_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        magx_reg  <= magx_next;
        magy_reg  <= magy_next;
        n_reg     <= n_next;
        hm_reg    <= hm_next;
        prod_reg  <= prod_next;
        i1_reg    <= i1_next;
        i2_reg    <= i2_next;
        nv_reg    <= nv_next;
        amp_reg   <= amp_next;
        total_reg <= total_next;
        out_reg   <= out_next;
        for (int a = 0; a < 4; a++)
            acc_reg[a] <= acc_next[a];
    end

    assign noise_sum = out_reg;

endmodule

// ===== rtl/value_noise_octave_sum.sv =====
// Fractal value noise over a sequence of octaves for one (x, y) point.
// Input channel: in_valid/in_ready carry one word of x_coord and y_coord, both
// signed Q16.16. Output channel: out_valid/out_ready carry one word of
// noise_sum, signed Q9.30, saturated to its 40-bit range.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is octave_count, index 1 is persistence (Q0.16, 65536 is one).
// cfg_ready is always high; write only while no point is in flight.
// A word runs L = min(octave_count, MAX_OCTAVES) - 1 octaves (zero if the
// count is 0 or 1) between acceptance and out_valid. Each octave clears the
// smoothing sums, runs sixteen lattice hashes of five steps each on the
// 32-bit hash multipliers, then does the blending, scaling and amplitude update.
// One point is worked on at a time; in_ready is high only while idle.
// A finished word sits in the output register; the next point may be accepted
// while it waits, but a new result is held back until the old one is taken,
// so a stalled receiver stalls the block after at most one more point.
// Reset clears the handshake state and restores octave_count to 8 and
// persistence to 32768.
module value_noise_octave_sum
    import vnos_pkg::*;
#(
    parameter int MAX_OCTAVES       = MAX_OCTAVES_DEF,
    parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   x_coord,
    input  logic signed [31:0]   y_coord,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [39:0]   noise_sum,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_data
);

    localparam int LOOP_W = $clog2(MAX_OCTAVES);

    logic [4:0]        octave_count_reg, octave_count_next;
    logic [16:0]       persistence_reg, persistence_next;
    logic [5:0]        cnt;
    logic [LOOP_W-1:0] loops;
    logic [16:0]       persist_eff;
    dp_cmd_t           cmd;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_comb
    begin
        octave_count_next = octave_count_reg;
        persistence_next  = persistence_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OCTAVE_COUNT: octave_count_next = cfg_data[4:0];
                REG_PERSISTENCE:  persistence_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCTAVE_COUNT_RST;
            persistence_reg  <= PERSIST_RST;
        end
        else
        begin
            octave_count_reg <= octave_count_next;
            persistence_reg  <= persistence_next;
        end
    end

    // Counts above the octave limit act as the limit; 0 and 1 run no octave.
    assign cnt = ({1'b0, octave_count_reg} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                              : {1'b0, octave_count_reg};
    assign loops = (cnt == 6'd0) ? '0 : LOOP_W'(cnt - 6'd1);
    assign persist_eff = (persistence_reg > PERSIST_ONE) ? PERSIST_ONE : persistence_reg;

    vnos_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .loops    (loops),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    vnos_dp #(
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .persistence(persist_eff),
        .noise_sum  (noise_sum)
    );

    // Once a point is taken, in_ready is low in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after a point was accepted");

    // A new result is only raised from the busy side, never while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("out_valid rose while the block was idle");

endmodule
